// ===== design/midi_byte_stream_parser_assert.svh =====
// Assertion macros for the MIDI byte stream parser.
`ifndef MIDI_BYTE_STREAM_PARSER_ASSERT_SVH
`define MIDI_BYTE_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MBSP_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MBSP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== design/mbsp_pkg.sv =====
// Shared types, byte codes and helpers for the MIDI byte stream parser.
package mbsp_pkg;

  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_MTC_QF      = 8'hF1;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
  localparam logic [3:0] HI_NOTE_ON     = 4'h9;
  localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
  localparam logic [3:0] HI_SYSTEM      = 4'hF;
  localparam logic [6:0] NOTE_OFF_VEL   = 7'h40;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [31:0] stamp;
    logic [1:0]  msg_length;
    logic [6:0]  data_second;
    logic [6:0]  data_first;
    logic [7:0]  status_out;
  } msg_t;

  typedef struct packed {
    logic [31:0] frame_time;
    logic [7:0]  rx_byte;
  } rx_item_t;

  function automatic logic [1:0] chan_data_len(input logic [7:0] st);
    logic [1:0] len;
    len = (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS) ? 2'd1 : 2'd2;
    return len;
  endfunction

endpackage

// ===== design/midi_byte_stream_parser.sv =====
// MIDI byte stream parser top level: input stage, parser, output register.
//
// Slave stream takes one received MIDI byte per transaction with the frame
// counter value at its arrival. Master stream delivers one assembled message
// per transaction: status (after the NoteOn with zero velocity to NoteOff
// rewrite), two data bytes, length and the frame time of the completing byte.
// Running status is kept for channel messages; system bytes clear it, SysEx
// start/end bytes and orphan data bytes produce nothing, and messages whose
// collected data bytes have bit 7 set are discarded.
// A message passes from the transaction of its last byte through the input
// register and the parser logic into the output register.
// Throughput: one byte per cycle while the sink does not stall.
// When the sink stalls, the output register holds its message and at most one more
// byte is taken into the input register; the slave side then stalls too.
// Reset clears the running status, the partial message and both valid flags.
module midi_byte_stream_parser
  import mbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // rx_byte[7:0], frame_time[39:8]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // status_out[7:0], data_first[14:8],
                                               // data_second[21:15], msg_length[23:22],
                                               // stamp[55:24]
);

`include "midi_byte_stream_parser_assert.svh"

  logic     advance;
  logic     item_valid;
  rx_item_t item;
  logic     emit;
  msg_t     msg;

  mbsp_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  mbsp_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (item_valid && advance),
    .item (item),
    .emit (emit),
    .msg  (msg)
  );

  mbsp_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .emit          (emit),
    .msg           (msg),
    .advance       (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `MBSP_ASSERT_NOW(a_len_nonzero, clk, rst, m_axis_tvalid,
                   m_axis_tdata[23:22] != 2'd0, "zero message length")
  `MBSP_ASSERT_NOW(a_status_msb, clk, rst, m_axis_tvalid,
                   m_axis_tdata[7], "status byte without bit 7")
  `MBSP_ASSERT_NOW(a_noteon_vel, clk, rst,
                   m_axis_tvalid && m_axis_tdata[7:4] == HI_NOTE_ON,
                   m_axis_tdata[21:15] != 7'd0, "NoteOn with zero velocity emitted")
  `MBSP_ASSERT_NEXT(a_item_held, clk, rst, item_valid && !advance,
                    item_valid, "held input byte lost")

endmodule

// ===== design/mbsp_in_stage.sv =====
// Input register stage: holds one accepted byte transaction for the parser.
module mbsp_in_stage
  import mbsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic                 advance,
  output logic                 item_valid,
  output rx_item_t             item
);

  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= rx_item_t'(s_axis_tdata);
    end
  end

endmodule

// ===== design/mbsp_parser.sv =====
// Running-status message assembler: parser state and next-message logic.
module mbsp_parser
  import mbsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  rx_item_t item,
  output logic     emit,
  output msg_t     msg
);

  logic [7:0] running_status, running_status_next;
  logic [7:0] held_status, held_status_next;
  logic [7:0] held_first, held_first_next;
  logic [7:0] held_second, held_second_next;
  logic [1:0] bytes_remaining, bytes_remaining_next;
  logic [1:0] fill_slot, fill_slot_next;
  logic [1:0] data_count, data_count_next;
  logic       complete;
  logic [7:0] b;
  logic       fixup;

  assign b = item.rx_byte;

  always_comb begin
    running_status_next  = running_status;
    held_status_next     = held_status;
    held_first_next      = held_first;
    held_second_next     = held_second;
    bytes_remaining_next = bytes_remaining;
    fill_slot_next       = fill_slot;
    data_count_next      = data_count;
    complete             = 1'b0;
    if (fire) begin
      if (bytes_remaining != 2'd0) begin
        if (fill_slot == 2'd1) begin
          held_first_next = b;
        end else begin
          held_second_next = b;
        end
        fill_slot_next       = fill_slot + 2'd1;
        bytes_remaining_next = bytes_remaining - 2'd1;
        complete             = (bytes_remaining == 2'd1);
      end else if (b[7]) begin
        held_status_next = b;
        held_first_next  = 8'd0;
        held_second_next = 8'd0;
        fill_slot_next   = 2'd1;
        if (b[7:4] != HI_SYSTEM) begin
          running_status_next = b;
          data_count_next     = chan_data_len(b);
        end else begin
          running_status_next = 8'd0;
          if (b == ST_SONG_POS) begin
            data_count_next = 2'd2;
          end else if (b inside {ST_MTC_QF, ST_SONG_SEL}) begin
            data_count_next = 2'd1;
          end else begin
            data_count_next = 2'd0;
          end
        end
        bytes_remaining_next = data_count_next;
        complete = (data_count_next == 2'd0) && !(b inside {ST_SYSEX_START, ST_SYSEX_END});
      end else if (running_status != 8'd0) begin
        held_status_next = running_status;
        held_first_next  = b;
        held_second_next = 8'd0;
        data_count_next  = chan_data_len(running_status);
        if (data_count_next == 2'd1) begin
          complete = 1'b1;
        end else begin
          fill_slot_next       = 2'd2;
          bytes_remaining_next = 2'd1;
        end
      end
    end
  end

  assign emit  = complete && !held_first_next[7] && !held_second_next[7];
  assign fixup = (held_status_next[7:4] == HI_NOTE_ON) && (held_second_next == 8'd0);

  always_comb begin
    msg.status_out  = fixup ? {HI_NOTE_OFF, held_status_next[3:0]} : held_status_next;
    msg.data_first  = held_first_next[6:0];
    msg.data_second = fixup ? NOTE_OFF_VEL : held_second_next[6:0];
    msg.msg_length  = data_count_next + 2'd1;
    msg.stamp       = item.frame_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status  <= 8'd0;
      held_status     <= 8'd0;
      held_first      <= 8'd0;
      held_second     <= 8'd0;
      bytes_remaining <= 2'd0;
      fill_slot       <= 2'd0;
      data_count      <= 2'd0;
    end else begin
      running_status  <= running_status_next;
      held_status     <= held_status_next;
      held_first      <= held_first_next;
      held_second     <= held_second_next;
      bytes_remaining <= bytes_remaining_next;
      fill_slot       <= fill_slot_next;
      data_count      <= data_count_next;
    end
  end

endmodule

// ===== design/mbsp_out_stage.sv =====
// Output register: holds one assembled message until the sink takes it.
module mbsp_out_stage
  import mbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  emit,
  input  msg_t                  msg,
  output logic                  advance,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  assign advance = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_axis_tdata <= OUT_DATA_W'(msg);
    end
  end

endmodule
